@@ design/ppcfd_pkg.sv @@
// Package for the PowerPC instruction field decoder.
// Holds the operation codes, opcode constants, the decode result struct
// and the primary-31 extended-opcode lookup. No dependencies.
`timescale 1ns / 1ps

package ppcfd_pkg;

  localparam int unsigned OP_W  = 6;
  localparam int unsigned REG_W = 5;
  localparam int unsigned IMM_W = 12;
  localparam int unsigned XO_W  = 10;

  // Primary opcodes
  localparam logic [5:0] PRI_PS      = 6'd4;
  localparam logic [5:0] PRI_RLWIMI  = 6'd20;
  localparam logic [5:0] PRI_RLWINM  = 6'd21;
  localparam logic [5:0] PRI_RLWNM   = 6'd23;
  localparam logic [5:0] PRI_X31     = 6'd31;
  localparam logic [5:0] PRI_PSQ_L   = 6'd56;
  localparam logic [5:0] PRI_PSQ_LU  = 6'd57;
  localparam logic [5:0] PRI_PSQ_ST  = 6'd60;
  localparam logic [5:0] PRI_PSQ_STU = 6'd61;

  // Primary-4 extended opcodes
  localparam logic [XO_W-1:0] XO_PS_ADD  = 10'd21;
  localparam logic [XO_W-1:0] XO_PS_SUB  = 10'd20;
  localparam logic [XO_W-1:0] XO_PS_DIV  = 10'd18;
  localparam logic [XO_W-1:0] XO_PS_MR   = 10'd72;
  localparam logic [XO_W-1:0] XO_PS_NEG  = 10'd40;
  localparam logic [4:0]      XO_PS_MUL  = 5'd25;
  localparam logic [4:0]      XO_PS_MADD = 5'd29;
  localparam logic [4:0]      XO_PS_MSUB = 5'd28;

  // Primary-31 extended opcodes
  localparam logic [XO_W-1:0] XO_CMPW   = 10'd0;
  localparam logic [XO_W-1:0] XO_CMPLW  = 10'd32;
  localparam logic [XO_W-1:0] XO_MULLW  = 10'd235;
  localparam logic [XO_W-1:0] XO_MULHW  = 10'd75;
  localparam logic [XO_W-1:0] XO_MULHWU = 10'd11;
  localparam logic [XO_W-1:0] XO_DIVW   = 10'd491;
  localparam logic [XO_W-1:0] XO_DIVWU  = 10'd459;
  localparam logic [XO_W-1:0] XO_AND    = 10'd28;
  localparam logic [XO_W-1:0] XO_OR     = 10'd444;
  localparam logic [XO_W-1:0] XO_XOR    = 10'd316;
  localparam logic [XO_W-1:0] XO_NAND   = 10'd476;
  localparam logic [XO_W-1:0] XO_NOR    = 10'd124;
  localparam logic [XO_W-1:0] XO_EQV    = 10'd284;
  localparam logic [XO_W-1:0] XO_ANDC   = 10'd60;
  localparam logic [XO_W-1:0] XO_ORC    = 10'd412;
  localparam logic [XO_W-1:0] XO_SLW    = 10'd24;
  localparam logic [XO_W-1:0] XO_SRW    = 10'd536;
  localparam logic [XO_W-1:0] XO_SRAW   = 10'd792;
  localparam logic [XO_W-1:0] XO_SRAWI  = 10'd824;
  localparam logic [XO_W-1:0] XO_ADD    = 10'd266;
  localparam logic [XO_W-1:0] XO_SUBF   = 10'd40;
  localparam logic [XO_W-1:0] XO_NEG    = 10'd104;

  // Dense operation codes
  localparam logic [OP_W-1:0] OP_NONE    = 6'd0;
  localparam logic [OP_W-1:0] OP_RLWINM  = 6'd0;
  localparam logic [OP_W-1:0] OP_RLWIMI  = 6'd1;
  localparam logic [OP_W-1:0] OP_RLWNM   = 6'd2;
  localparam logic [OP_W-1:0] OP_PSQ_L   = 6'd3;
  localparam logic [OP_W-1:0] OP_PSQ_LU  = 6'd4;
  localparam logic [OP_W-1:0] OP_PSQ_ST  = 6'd5;
  localparam logic [OP_W-1:0] OP_PSQ_STU = 6'd6;
  localparam logic [OP_W-1:0] OP_PS_ADD  = 6'd7;
  localparam logic [OP_W-1:0] OP_PS_SUB  = 6'd8;
  localparam logic [OP_W-1:0] OP_PS_DIV  = 6'd9;
  localparam logic [OP_W-1:0] OP_PS_MR   = 6'd10;
  localparam logic [OP_W-1:0] OP_PS_NEG  = 6'd11;
  localparam logic [OP_W-1:0] OP_PS_MUL  = 6'd12;
  localparam logic [OP_W-1:0] OP_PS_MADD = 6'd13;
  localparam logic [OP_W-1:0] OP_PS_MSUB = 6'd14;
  localparam logic [OP_W-1:0] OP_CMPW    = 6'd15;
  localparam logic [OP_W-1:0] OP_CMPLW   = 6'd16;
  localparam logic [OP_W-1:0] OP_MULLW   = 6'd17;
  localparam logic [OP_W-1:0] OP_MULHW   = 6'd18;
  localparam logic [OP_W-1:0] OP_MULHWU  = 6'd19;
  localparam logic [OP_W-1:0] OP_DIVW    = 6'd20;
  localparam logic [OP_W-1:0] OP_DIVWU   = 6'd21;
  localparam logic [OP_W-1:0] OP_AND     = 6'd22;
  localparam logic [OP_W-1:0] OP_OR      = 6'd23;
  localparam logic [OP_W-1:0] OP_XOR     = 6'd24;
  localparam logic [OP_W-1:0] OP_NAND    = 6'd25;
  localparam logic [OP_W-1:0] OP_NOR     = 6'd26;
  localparam logic [OP_W-1:0] OP_EQV     = 6'd27;
  localparam logic [OP_W-1:0] OP_ANDC    = 6'd28;
  localparam logic [OP_W-1:0] OP_ORC     = 6'd29;
  localparam logic [OP_W-1:0] OP_SLW     = 6'd30;
  localparam logic [OP_W-1:0] OP_SRW     = 6'd31;
  localparam logic [OP_W-1:0] OP_SRAW    = 6'd32;
  localparam logic [OP_W-1:0] OP_SRAWI   = 6'd33;
  localparam logic [OP_W-1:0] OP_ADD     = 6'd34;
  localparam logic [OP_W-1:0] OP_SUBF    = 6'd35;
  localparam logic [OP_W-1:0] OP_NEG     = 6'd36;

  typedef struct packed {
    logic                    valid;
    logic [OP_W-1:0]         op;
    logic [REG_W-1:0]        rd;
    logic [REG_W-1:0]        ra;
    logic [REG_W-1:0]        rb;
    logic [REG_W-1:0]        sh;
    logic [REG_W-1:0]        mb;
    logic [REG_W-1:0]        me;
    logic signed [IMM_W-1:0] imm;
  } dec_t;

  typedef struct packed {
    logic            hit;
    logic [OP_W-1:0] op;
  } op31_t;

  function automatic op31_t op31_lookup(input logic [XO_W-1:0] xo);
    op31_t r;
    r.hit = 1'b1;
    case (xo)
      XO_CMPW:   r.op = OP_CMPW;
      XO_CMPLW:  r.op = OP_CMPLW;
      XO_MULLW:  r.op = OP_MULLW;
      XO_MULHW:  r.op = OP_MULHW;
      XO_MULHWU: r.op = OP_MULHWU;
      XO_DIVW:   r.op = OP_DIVW;
      XO_DIVWU:  r.op = OP_DIVWU;
      XO_AND:    r.op = OP_AND;
      XO_OR:     r.op = OP_OR;
      XO_XOR:    r.op = OP_XOR;
      XO_NAND:   r.op = OP_NAND;
      XO_NOR:    r.op = OP_NOR;
      XO_EQV:    r.op = OP_EQV;
      XO_ANDC:   r.op = OP_ANDC;
      XO_ORC:    r.op = OP_ORC;
      XO_SLW:    r.op = OP_SLW;
      XO_SRW:    r.op = OP_SRW;
      XO_SRAW:   r.op = OP_SRAW;
      XO_SRAWI:  r.op = OP_SRAWI;
      XO_ADD:    r.op = OP_ADD;
      XO_SUBF:   r.op = OP_SUBF;
      XO_NEG:    r.op = OP_NEG;
      default: begin
        r.hit = 1'b0;
        r.op  = OP_NONE;
      end
    endcase
    return r;
  endfunction

endpackage

@@ design/ppc_instruction_field_decoder_top.sv @@
// Top level of the PowerPC instruction field decoder: input register,
// decode logic and result register. Depends on ppcfd_pkg, ppcfd_decode.
// Flow: a transfer is held in the input register, and its decode is loaded into
// the result register as the result strobe done rises.
// Throughput: one instruction per cycle; busy is never raised, since the
// input register feeds the decode and the result register every cycle.
// Reset: synchronous rst clears the input valid flag and the done strobe only.
`timescale 1ns / 1ps

module ppc_instruction_field_decoder_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [31:0]                          instr_word,
  output logic                                 done,
  output logic                                 valid_res,
  output logic [ppcfd_pkg::OP_W-1:0]           op_code,
  output logic [ppcfd_pkg::REG_W-1:0]          reg_d,
  output logic [ppcfd_pkg::REG_W-1:0]          reg_a,
  output logic [ppcfd_pkg::REG_W-1:0]          reg_b,
  output logic [ppcfd_pkg::REG_W-1:0]          shift_amt,
  output logic [ppcfd_pkg::REG_W-1:0]          mask_begin,
  output logic [ppcfd_pkg::REG_W-1:0]          mask_end,
  output logic signed [ppcfd_pkg::IMM_W-1:0]   immediate
);
  import ppcfd_pkg::*;

  logic        in_valid;
  logic [31:0] in_word;
  dec_t        dec;
  dec_t        res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start & ~busy;
      done     <= in_valid;
    end
  end

  // payload registers hold no reset
  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      in_word <= instr_word;
    end
    if (in_valid) begin
      res <= dec;
    end
  end

  ppcfd_decode u_decode (
    .word (in_word),
    .dec  (dec)
  );

  assign valid_res  = res.valid;
  assign op_code    = res.op;
  assign reg_d      = res.rd;
  assign reg_a      = res.ra;
  assign reg_b      = res.rb;
  assign shift_amt  = res.sh;
  assign mask_begin = res.mb;
  assign mask_end   = res.me;
  assign immediate  = res.imm;

endmodule

@@ design/ppcfd_decode.sv @@
// Combinational decode of one instruction word into operation and fields.
// Depends on ppcfd_pkg.
`timescale 1ns / 1ps

module ppcfd_decode (
  input  logic [31:0]     word,
  output ppcfd_pkg::dec_t dec
);
  import ppcfd_pkg::*;

  logic [5:0]       primary;
  logic [REG_W-1:0] r6, r11, r16, r21, r26;
  logic [XO_W-1:0]  xo10;
  op31_t            hit31;

  // Big-endian bit numbering: instruction bit i is word[31-i]
  assign primary = word[31:26];
  assign r6      = word[25:21];
  assign r11     = word[20:16];
  assign r16     = word[15:11];
  assign r21     = word[10:6];
  assign r26     = word[5:1];
  assign xo10    = word[10:1];
  assign hit31   = op31_lookup(xo10);

  always_comb begin
    dec = '0;
    if (primary inside {PRI_RLWIMI, PRI_RLWINM, PRI_RLWNM}) begin
      dec.valid = 1'b1;
      dec.op = (primary == PRI_RLWINM) ? OP_RLWINM :
               (primary == PRI_RLWIMI) ? OP_RLWIMI : OP_RLWNM;
      dec.rd = r6;
      dec.ra = r11;
      dec.rb = r16;
      dec.sh = r16;
      dec.mb = r21;
      dec.me = r26;
    end else if (primary inside {PRI_PSQ_L, PRI_PSQ_LU, PRI_PSQ_ST, PRI_PSQ_STU}) begin
      dec.valid = 1'b1;
      dec.op = (primary == PRI_PSQ_L)  ? OP_PSQ_L :
               (primary == PRI_PSQ_LU) ? OP_PSQ_LU :
               (primary == PRI_PSQ_ST) ? OP_PSQ_ST : OP_PSQ_STU;
      dec.rd  = r6;
      dec.ra  = r11;
      dec.sh  = {4'd0, word[15]};
      dec.mb  = {2'd0, word[14:12]};
      dec.imm = signed'(word[11:0]);
    end else if (primary == PRI_PS) begin
      dec.valid = 1'b1;
      dec.rd    = r6;
      // full 10-bit forms take priority over the 5-bit multiply forms
      if (xo10 == XO_PS_ADD) begin
        dec.op = OP_PS_ADD; dec.ra = r11; dec.rb = r16;
      end else if (xo10 == XO_PS_SUB) begin
        dec.op = OP_PS_SUB; dec.ra = r11; dec.rb = r16;
      end else if (xo10 == XO_PS_DIV) begin
        dec.op = OP_PS_DIV; dec.ra = r11; dec.rb = r16;
      end else if (xo10 == XO_PS_MR) begin
        dec.op = OP_PS_MR; dec.rb = r16;
      end else if (xo10 == XO_PS_NEG) begin
        dec.op = OP_PS_NEG; dec.rb = r16;
      end else if (r26 == XO_PS_MUL) begin
        dec.op = OP_PS_MUL; dec.ra = r11; dec.rb = r21;
      end else if (r26 == XO_PS_MADD) begin
        dec.op = OP_PS_MADD; dec.ra = r11; dec.rb = r21;
      end else if (r26 == XO_PS_MSUB) begin
        dec.op = OP_PS_MSUB; dec.ra = r11; dec.rb = r21;
      end else begin
        dec.valid = 1'b0;
        dec.rd    = '0;
      end
    end else if (primary == PRI_X31 && hit31.hit) begin
      if (hit31.op == OP_CMPW || hit31.op == OP_CMPLW) begin
        // drop compares with the L bit set
        if (!word[21]) begin
          dec.valid = 1'b1;
          dec.op    = hit31.op;
          dec.rd    = {2'd0, word[25:23]};
          dec.ra    = r11;
          dec.rb    = r16;
        end
      end else begin
        dec.valid = 1'b1;
        dec.op    = hit31.op;
        dec.rd    = r6;
        dec.ra    = r11;
        if (hit31.op == OP_SRAWI) begin
          dec.sh = r16;
        end else if (hit31.op != OP_NEG) begin
          dec.rb = r16;
        end
      end
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for ppc_instruction_field_decoder_top.
// Drives directed and random PowerPC words, predicts each decode and compares
// every result field. Depends on ppcfd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import ppcfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 50000;

  // Primary-31 extended opcodes and the dense codes they map to, in step.
  localparam logic [XO_W-1:0] X31_XO [22] = '{
    XO_CMPW, XO_CMPLW, XO_MULLW, XO_MULHW, XO_MULHWU, XO_DIVW, XO_DIVWU,
    XO_AND, XO_OR, XO_XOR, XO_NAND, XO_NOR, XO_EQV, XO_ANDC, XO_ORC,
    XO_SLW, XO_SRW, XO_SRAW, XO_SRAWI, XO_ADD, XO_SUBF, XO_NEG
  };
  localparam logic [OP_W-1:0] X31_OP [22] = '{
    OP_CMPW, OP_CMPLW, OP_MULLW, OP_MULHW, OP_MULHWU, OP_DIVW, OP_DIVWU,
    OP_AND, OP_OR, OP_XOR, OP_NAND, OP_NOR, OP_EQV, OP_ANDC, OP_ORC,
    OP_SLW, OP_SRW, OP_SRAW, OP_SRAWI, OP_ADD, OP_SUBF, OP_NEG
  };
  localparam logic [XO_W-1:0] PS_XO10 [5] = '{
    XO_PS_ADD, XO_PS_SUB, XO_PS_DIV, XO_PS_MR, XO_PS_NEG
  };
  localparam logic [4:0] PS_XO5 [3] = '{XO_PS_MUL, XO_PS_MADD, XO_PS_MSUB};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] instr_word = '0;
  logic        busy;
  logic        done;
  logic        valid_res;
  logic [OP_W-1:0]         op_code;
  logic [REG_W-1:0]        reg_d;
  logic [REG_W-1:0]        reg_a;
  logic [REG_W-1:0]        reg_b;
  logic [REG_W-1:0]        shift_amt;
  logic [REG_W-1:0]        mask_begin;
  logic [REG_W-1:0]        mask_end;
  logic signed [IMM_W-1:0] immediate;

  dec_t        pending_decodes[$];
  int unsigned err_count = 0;
  int unsigned cycle_cnt = 0;
  bit          gaps_on = 1'b0;

  ppc_instruction_field_decoder_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .instr_word(instr_word),
    .done(done), .valid_res(valid_res), .op_code(op_code), .reg_d(reg_d),
    .reg_a(reg_a), .reg_b(reg_b), .shift_amt(shift_amt),
    .mask_begin(mask_begin), .mask_end(mask_end), .immediate(immediate)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("ppc_instruction_field_decoder_top regression: fail");
      $finish;
    end
  end

  // Bit 0 of the word is the MSB, so field (first..last) is w[31-first:31-last].
  function automatic dec_t decode_fields(input logic [31:0] w);
    dec_t           d;
    logic [5:0]     pri;
    logic [XO_W-1:0] xo;
    logic [4:0]     r6, r11, r16, r21, r26;
    d   = '0;
    pri = w[31:26];
    r6  = w[25:21];
    r11 = w[20:16];
    r16 = w[15:11];
    r21 = w[10:6];
    r26 = w[5:1];
    xo  = w[10:1];
    case (pri)
      PRI_RLWINM, PRI_RLWIMI, PRI_RLWNM: begin
        d.valid = 1'b1;
        d.op = (pri == PRI_RLWINM) ? OP_RLWINM :
               (pri == PRI_RLWIMI) ? OP_RLWIMI : OP_RLWNM;
        d.rd = r6;
        d.ra = r11;
        d.rb = r16;
        d.sh = r16;
        d.mb = r21;
        d.me = r26;
      end
      PRI_PSQ_L, PRI_PSQ_LU, PRI_PSQ_ST, PRI_PSQ_STU: begin
        d.valid = 1'b1;
        d.op = (pri == PRI_PSQ_L)  ? OP_PSQ_L :
               (pri == PRI_PSQ_LU) ? OP_PSQ_LU :
               (pri == PRI_PSQ_ST) ? OP_PSQ_ST : OP_PSQ_STU;
        d.rd  = r6;
        d.ra  = r11;
        d.sh  = {4'b0, w[15]};
        d.mb  = {2'b0, w[14:12]};
        d.imm = w[11:0];
      end
      PRI_PS: begin
        d.valid = 1'b1;
        d.rd = r6;
        d.ra = r11;
        d.rb = r16;
        // Full 10-bit opcodes take priority over the 5-bit multiply forms.
        if (xo == XO_PS_ADD) d.op = OP_PS_ADD;
        else if (xo == XO_PS_SUB) d.op = OP_PS_SUB;
        else if (xo == XO_PS_DIV) d.op = OP_PS_DIV;
        else if (xo == XO_PS_MR || xo == XO_PS_NEG) begin
          d.op = (xo == XO_PS_MR) ? OP_PS_MR : OP_PS_NEG;
          d.ra = '0;
        end else if (r26 == XO_PS_MUL || r26 == XO_PS_MADD || r26 == XO_PS_MSUB) begin
          d.op = (r26 == XO_PS_MUL)  ? OP_PS_MUL :
                 (r26 == XO_PS_MADD) ? OP_PS_MADD : OP_PS_MSUB;
          d.rb = r21;
        end else begin
          d = '0;
        end
      end
      PRI_X31: begin
        for (int i = 0; i < 22; i++) begin
          if (!d.valid && X31_XO[i] == xo) begin
            d.valid = 1'b1;
            d.op    = X31_OP[i];
          end
        end
        if (d.valid) begin
          d.rd = r6;
          d.ra = r11;
          d.rb = r16;
          if (d.op == OP_CMPW || d.op == OP_CMPLW) begin
            // Reject the 64-bit compare (L set); crD is the top three bits.
            if (w[21]) d = '0;
            else d.rd = {2'b0, w[25:23]};
          end else if (d.op == OP_SRAWI) begin
            d.sh = r16;
            d.rb = '0;
          end else if (d.op == OP_NEG) begin
            d.rb = '0;
          end
        end
      end
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] x_word(input logic [5:0] pri, input logic [4:0] rd,
                                         input logic [4:0] ra, input logic [4:0] rb,
                                         input logic [XO_W-1:0] xo, input logic rc);
    return {pri, rd, ra, rb, xo, rc};
  endfunction

  // Record each transfer, then check the result strobed at this edge.
  always @(posedge clk) begin
    dec_t exp_d;
    if (!rst && start && !busy) pending_decodes.push_back(decode_fields(instr_word));
    if (!rst && done) begin
      if (pending_decodes.size() == 0) begin
        $error("result strobe with no decode pending");
        err_count++;
      end else begin
        exp_d = pending_decodes.pop_front();
        if (valid_res !== exp_d.valid) begin
          $error("valid_res exp %0d got %0d", exp_d.valid, valid_res);
          err_count++;
        end
        if (op_code !== exp_d.op) begin
          $error("op_code exp %0d got %0d", exp_d.op, op_code);
          err_count++;
        end
        if (reg_d !== exp_d.rd) begin
          $error("reg_d exp %0d got %0d", exp_d.rd, reg_d);
          err_count++;
        end
        if (reg_a !== exp_d.ra) begin
          $error("reg_a exp %0d got %0d", exp_d.ra, reg_a);
          err_count++;
        end
        if (reg_b !== exp_d.rb) begin
          $error("reg_b exp %0d got %0d", exp_d.rb, reg_b);
          err_count++;
        end
        if (shift_amt !== exp_d.sh) begin
          $error("shift_amt exp %0d got %0d", exp_d.sh, shift_amt);
          err_count++;
        end
        if (mask_begin !== exp_d.mb) begin
          $error("mask_begin exp %0d got %0d", exp_d.mb, mask_begin);
          err_count++;
        end
        if (mask_end !== exp_d.me) begin
          $error("mask_end exp %0d got %0d", exp_d.me, mask_end);
          err_count++;
        end
        if (immediate !== exp_d.imm) begin
          $error("immediate exp %0d got %0d", exp_d.imm, immediate);
          err_count++;
        end
      end
    end
  end

  // Hold start and the word until the transfer edge; start stays high after unless a gap is inserted.
  task automatic send_word(input logic [31:0] w);
    start      <= 1'b1;
    instr_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start      <= 1'b0;
      instr_word <= $urandom();
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int unsigned sel;
    w   = $urandom();
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      // raw noise
    end else if (sel < 27) begin
      case ($urandom_range(0, 2))
        0: w[31:26] = PRI_RLWINM;
        1: w[31:26] = PRI_RLWIMI;
        default: w[31:26] = PRI_RLWNM;
      endcase
    end else if (sel < 42) begin
      case ($urandom_range(0, 3))
        0: w[31:26] = PRI_PSQ_L;
        1: w[31:26] = PRI_PSQ_LU;
        2: w[31:26] = PRI_PSQ_ST;
        default: w[31:26] = PRI_PSQ_STU;
      endcase
    end else if (sel < 62) begin
      w[31:26] = PRI_PS;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: w[10:1] = PS_XO10[$urandom_range(0, 4)];
        5, 6, 7, 8: w[5:1] = PS_XO5[$urandom_range(0, 2)];
        default: ;  // broken extended opcode
      endcase
    end else begin
      w[31:26] = PRI_X31;
      if ($urandom_range(0, 9) != 0) w[10:1] = X31_XO[$urandom_range(0, 21)];
      // Keep the compare L bit mostly clear so compares decode.
      if ((w[10:1] == XO_CMPW || w[10:1] == XO_CMPLW) && $urandom_range(0, 3) != 0)
        w[21] = 1'b0;
    end
    return w;
  endfunction

  task automatic test_unmatched_words();
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(x_word(PRI_PS, 5'd3, 5'd4, 5'd5, 10'd0, 1'b0));
  endtask

  task automatic test_rotate_forms();
    send_word({PRI_RLWINM, 26'h000_0000});
    send_word({PRI_RLWIMI, 26'h3FF_FFFF});
    send_word({PRI_RLWNM, 5'd31, 5'd0, 5'd17, 5'd0, 5'd31, 1'b1});
  endtask

  task automatic test_psq_forms();
    send_word({PRI_PSQ_L, 5'd1, 5'd2, 1'b0, 3'd0, 12'h7FF});
    send_word({PRI_PSQ_LU, 5'd31, 5'd31, 1'b1, 3'd7, 12'h800});
    send_word({PRI_PSQ_ST, 26'h3FF_FFFF});
    send_word({PRI_PSQ_STU, 26'h000_0000});
  endtask

  task automatic test_ps_arith_forms();
    send_word(x_word(PRI_PS, 5'd31, 5'd31, 5'd31, XO_PS_ADD, 1'b1));
    send_word(x_word(PRI_PS, 5'd7, 5'd9, 5'd11, XO_PS_MR, 1'b0));
    send_word({PRI_PS, 5'd2, 5'd3, 5'd4, 5'd31, XO_PS_MADD, 1'b1});
  endtask

  task automatic test_op31_forms();
    send_word(x_word(PRI_X31, 5'b11100, 5'd31, 5'd31, XO_CMPW, 1'b0));
    send_word(x_word(PRI_X31, 5'b00001, 5'd1, 5'd2, XO_CMPW, 1'b0));
    send_word(x_word(PRI_X31, 5'b11101, 5'd1, 5'd2, XO_CMPLW, 1'b0));
    send_word(x_word(PRI_X31, 5'd3, 5'd4, 5'd5, XO_ADD | 10'h200, 1'b0));
    send_word(x_word(PRI_X31, 5'd6, 5'd7, 5'd31, XO_SRAWI, 1'b1));
    send_word(x_word(PRI_X31, 5'd8, 5'd9, 5'd30, XO_NEG, 1'b0));
    send_word(x_word(PRI_X31, 5'd0, 5'd31, 5'd0, XO_SUBF, 1'b1));
  endtask

  task automatic test_random_mix();
    for (int blk = 0; blk < 8; blk++) begin
      // Leave every third block without gaps.
      gaps_on = (blk % 3 != 2);
      repeat (50) send_word(random_word());
    end
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    repeat (100) send_word(random_word());
    start <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gaps_on = 1'b1;
    test_unmatched_words();
    test_rotate_forms();
    test_psq_forms();
    test_ps_arith_forms();
    test_op31_forms();
    test_random_mix();
    test_back_to_back();
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("ppc_instruction_field_decoder_top regression: pass");
    end else begin
      $display("ppc_instruction_field_decoder_top regression: fail");
    end
    $finish;
  end

endmodule

@@ ppc_instruction_field_decoder_top.f @@
design/ppcfd_pkg.sv
design/ppcfd_decode.sv
design/ppc_instruction_field_decoder_top.sv
verif/tb_top.sv
